/* sv/lppm_pkg.sv */
// ----------------------------------------------------------------------------
// lppm_pkg
// Types and codes shared by the linear probe position map unit.
// ----------------------------------------------------------------------------
package lppm_pkg;

	localparam int unsigned KeyW       = 32;
	localparam int unsigned ValW       = 32;
	localparam int unsigned FillW      = 11;
	localparam int unsigned FillLimitW = 10;
	localparam logic [FillLimitW-1:0] FillLimitReset = 10'd819;

	typedef enum logic [1:0] {
		KIND_INSERT     = 2'd0,
		KIND_LOOKUP     = 2'd1,
		KIND_SET_OFFSET = 2'd2,
		KIND_CLEAR      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_NULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [ValW-1:0] offset_value;
		logic [ValW-1:0] position;
		logic [KeyW-1:0] key;
	} row_t;

endpackage

/* sv/lppm_home.sv */
// ----------------------------------------------------------------------------
// lppm_home
// Home slot of a key: the key modulo the table size. A power-of-two size
// registers the low key bits as the slot; any other size uses a reciprocal
// multiplication registered in the product, quotient and slot registers.
// ----------------------------------------------------------------------------
module lppm_home #(
	parameter int unsigned TABLE_SIZE = 1024,
	parameter int unsigned SW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lppm_pkg::KeyW-1:0]     key,
	output logic                          done,
	output logic [SW-1:0]                 slot
);

	localparam bit IsPow2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

	generate
		if (IsPow2) begin : g_pow2
			logic          done_q;
			logic [SW-1:0] slot_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					slot_q <= key[SW-1:0];
				end
			end

			assign done = done_q;
			assign slot = slot_q;
		end else begin : g_mul
			// The quotient is the high half of the key times a rounded-up
			// reciprocal, corrected by a halved difference and a final shift.
			localparam int unsigned KW  = lppm_pkg::KeyW;
			localparam int unsigned PW  = 2 * KW;
			localparam int unsigned L   = $clog2(TABLE_SIZE);
			localparam int unsigned Sh2 = L - 1;
			localparam logic [63:0] MagicWide =
				((64'd1 << KW) * ((64'd1 << L) - 64'(TABLE_SIZE))) / 64'(TABLE_SIZE)
				+ 64'd1;
			localparam logic [KW-1:0] Magic   = MagicWide[KW-1:0];
			localparam logic [KW-1:0] Divisor = KW'(TABLE_SIZE);

			logic          v_s1;
			logic          v_s2;
			logic          done_q;
			logic [KW-1:0] key_s1;
			logic [PW-1:0] prod_s1;
			logic [KW-1:0] key_s2;
			logic [KW-1:0] quot_s2;
			logic [SW-1:0] slot_q;
			logic [KW-1:0] mul_hi;
			logic [KW-1:0] quot;
			logic [KW-1:0] rem;

			always_comb begin
				mul_hi = prod_s1[PW-1:KW];
				quot   = (mul_hi + ((key_s1 - mul_hi) >> 1)) >> Sh2;
				rem    = key_s2 - quot_s2 * Divisor;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					done_q <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_s1  <= key;
					prod_s1 <= PW'(key) * PW'(Magic);
				end
				if (v_s1) begin
					key_s2  <= key_s1;
					quot_s2 <= quot;
				end
				if (v_s2) begin
					slot_q <= rem[SW-1:0];
				end
			end

			assign done = done_q;
			assign slot = slot_q;
		end
	endgenerate

endmodule

/* sv/lppm_mem.sv */
// ----------------------------------------------------------------------------
// lppm_mem
// Slot memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lppm_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  lppm_pkg::row_t      wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output lppm_pkg::row_t      rd_data
);

	lppm_pkg::row_t mem [DEPTH];
	lppm_pkg::row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/linear_probe_position_map_unit.sv */
// ----------------------------------------------------------------------------
// linear_probe_position_map_unit
// Open-addressing hash table with linear probing that maps a nonzero key to
// a stored position and offset.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one beat per operation, and every
// request gives exactly one response beat on m_axis. The cfg channel writes
// the fill limit; the user is bound to write it while the unit is idle, as
// the block leaves that to the user. An operation runs one at a time. The
// home slot is registered in lppm_home, directly for a power-of-two table
// size and through product and quotient registers otherwise. The probe then
// reads the slot memory one slot a cycle with its single read port, and the
// next request beat is taken only once the response has moved to the output
// register. A null key or a refused insert skips the probe. A clear sweeps
// the slot memory one slot a cycle. After reset the same sweep empties the
// table, with s_axis_tready low; cfg is always ready and still takes writes.
// The response sits in an output register, so a new request is taken while
// an earlier response waits; a stalled receiver only holds the unit once the
// following response is ready as well.
// ----------------------------------------------------------------------------
module linear_probe_position_map_unit #(
	parameter int unsigned TABLE_SIZE = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // key, position, offset_value
	input  logic [1:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // found_position, found_offset
	output logic [1:0]   m_axis_tuser,  // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [9:0]   cfg_data
);

	localparam int unsigned SW = $clog2(TABLE_SIZE);
	localparam logic [SW-1:0] LastSlot = SW'(TABLE_SIZE - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_PROBE,
		S_DONE
	} state_t;

	state_t                              state_q;
	logic                                clr_op_q;
	logic [SW-1:0]                       clr_q;
	logic [lppm_pkg::FillW-1:0]          fill_q;
	logic [lppm_pkg::FillLimitW-1:0]     fill_limit_q;
	lppm_pkg::kind_t                     kind_q;
	logic [lppm_pkg::KeyW-1:0]           key_q;
	logic [lppm_pkg::ValW-1:0]           pos_q;
	logic [lppm_pkg::ValW-1:0]           off_q;
	logic [SW-1:0]                       addr_q;
	logic [SW-1:0]                       nxt_q;
	logic [SW-1:0]                       cnt_q;
	lppm_pkg::status_t                   res_status_q;
	logic [lppm_pkg::ValW-1:0]           res_pos_q;
	logic [lppm_pkg::ValW-1:0]           res_off_q;
	logic                                out_valid_q;
	lppm_pkg::status_t                   out_status_q;
	logic [lppm_pkg::ValW-1:0]           out_pos_q;
	logic [lppm_pkg::ValW-1:0]           out_off_q;

	logic                                in_beat;
	logic                                home_start;
	logic                                home_done;
	logic [SW-1:0]                       home_slot;
	logic                                wr_en;
	logic [SW-1:0]                       wr_addr;
	lppm_pkg::row_t                      wr_data;
	logic                                rd_en;
	logic [SW-1:0]                       rd_addr;
	lppm_pkg::row_t                      rd_data;
	logic                                hit;
	logic                                empty;
	logic                                out_free;

	function automatic logic [SW-1:0] step_down(input logic [SW-1:0] slot);
		step_down = (slot == '0) ? LastSlot : slot - 1'b1;
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign home_start    = in_beat &&
		(lppm_pkg::kind_t'(s_axis_tuser) != lppm_pkg::KIND_CLEAR);
	assign cfg_ready     = 1'b1;

	assign hit      = (rd_data.key == key_q);
	assign empty    = (rd_data.key == '0);
	assign out_free = !out_valid_q || m_axis_tready;

	lppm_home #(
		.TABLE_SIZE(TABLE_SIZE),
		.SW        (SW)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (home_start),
		.key   (s_axis_tdata[31:0]),
		.done  (home_done),
		.slot  (home_slot)
	);

	lppm_mem #(
		.DEPTH(TABLE_SIZE),
		.AW   (SW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Besides the clear sweep, writes happen only on the last probe cycle, and the
	// next read waits for S_HOME, so no slot is read while its write is pending.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '{offset_value: off_q, position: pos_q, key: key_q};
		rd_en   = 1'b0;
		rd_addr = nxt_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_HOME: begin
				rd_en   = home_done;
				rd_addr = home_slot;
			end
			S_PROBE: begin
				rd_en = 1'b1;
				if (hit && kind_q == lppm_pkg::KIND_SET_OFFSET) begin
					wr_en   = 1'b1;
					wr_data = '{offset_value: off_q, position: rd_data.position,
						key: key_q};
				end else if (!hit && empty && kind_q == lppm_pkg::KIND_INSERT) begin
					wr_en = 1'b1;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_op_q     <= 1'b0;
			clr_q        <= '0;
			fill_q       <= '0;
			fill_limit_q <= lppm_pkg::FillLimitReset;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fill_limit_q <= cfg_data;
			end
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_q == LastSlot) begin
						clr_q  <= '0;
						fill_q <= '0;
						if (clr_op_q) begin
							res_status_q <= lppm_pkg::ST_OK;
							res_pos_q    <= '0;
							res_off_q    <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_beat) begin
						kind_q <= lppm_pkg::kind_t'(s_axis_tuser);
						key_q  <= s_axis_tdata[31:0];
						pos_q  <= s_axis_tdata[63:32];
						off_q  <= s_axis_tdata[95:64];
						if (lppm_pkg::kind_t'(s_axis_tuser) == lppm_pkg::KIND_CLEAR) begin
							clr_op_q <= 1'b1;
							clr_q    <= '0;
							state_q  <= S_CLEAR;
						end else begin
							state_q <= S_HOME;
						end
					end
				end
				S_HOME: begin
					if (home_done) begin
						res_pos_q <= '0;
						res_off_q <= '0;
						if (key_q == '0) begin
							res_status_q <= (kind_q == lppm_pkg::KIND_INSERT) ?
								lppm_pkg::ST_NULL : lppm_pkg::ST_NOT_FOUND;
							state_q <= S_DONE;
						end else if (kind_q == lppm_pkg::KIND_INSERT &&
							fill_q >= {1'b0, fill_limit_q}) begin
							res_status_q <= lppm_pkg::ST_FULL;
							state_q      <= S_DONE;
						end else begin
							if (kind_q == lppm_pkg::KIND_INSERT) begin
								fill_q <= fill_q + 1'b1;
							end
							addr_q  <= home_slot;
							nxt_q   <= step_down(home_slot);
							cnt_q   <= '0;
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (hit) begin
						res_status_q <= lppm_pkg::ST_OK;
						res_pos_q    <= rd_data.position;
						res_off_q    <= (kind_q == lppm_pkg::KIND_SET_OFFSET) ?
							off_q : rd_data.offset_value;
						state_q      <= S_DONE;
					end else if (empty) begin
						if (kind_q == lppm_pkg::KIND_INSERT) begin
							res_status_q <= lppm_pkg::ST_OK;
							res_pos_q    <= pos_q;
							res_off_q    <= off_q;
						end else begin
							res_status_q <= lppm_pkg::ST_NOT_FOUND;
							res_pos_q    <= '0;
							res_off_q    <= '0;
						end
						state_q <= S_DONE;
					end else if (cnt_q == LastSlot) begin
						res_status_q <= (kind_q == lppm_pkg::KIND_INSERT) ?
							lppm_pkg::ST_FULL : lppm_pkg::ST_NOT_FOUND;
						res_pos_q    <= '0;
						res_off_q    <= '0;
						state_q      <= S_DONE;
					end else begin
						addr_q <= nxt_q;
						nxt_q  <= step_down(nxt_q);
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_pos_q    <= res_pos_q;
						out_off_q    <= res_off_q;
						clr_op_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_off_q, out_pos_q};

endmodule
